// ===== src/rtcep_pkg.sv =====
// Shared types, constants and calendar helpers for the RTC fields to epoch converter.
// No dependencies; imported by every module of the block.
package rtcep_pkg;

    // Status byte mode bits and hour byte flag position
    localparam int unsigned PmBit     = 7;
    localparam int unsigned BinaryBit = 2;
    localparam int unsigned Hour24Bit = 1;

    // Widths of the packed channel words
    localparam int unsigned FieldW   = 8;
    localparam int unsigned InDataW  = 56;
    localparam int unsigned InUserW  = 8;
    localparam int unsigned OutDataW = 32;
    localparam int unsigned EpochW   = 31;

    // Internal widths: days since 1970 stay below 2^15 over 1970..2037
    localparam int unsigned DaysW = 15;
    localparam int unsigned HourW = 5;
    localparam int unsigned MinW  = 6;
    localparam int unsigned SecW  = 6;

    // Calendar constants
    localparam logic [7:0]  CenturyLow   = 8'd19;
    localparam logic [7:0]  CenturyHigh  = 8'd99;
    localparam logic [7:0]  Century2000  = 8'd20;
    localparam logic [7:0]  YearMin19    = 8'd70;   // 1970 under century 19
    localparam logic [7:0]  YearMax19    = 8'd137;  // 2037 under century 19
    localparam logic [7:0]  YearMax20    = 8'd37;   // 2037 under base 2000
    localparam logic [7:0]  Offset19     = 8'd70;   // year offset from 1970
    localparam logic [7:0]  Offset20     = 8'd30;
    localparam logic [1:0]  LeapPhase    = 2'd2;    // 1972 is offset 2
    localparam logic [14:0] DaysPerYear  = 15'd365;
    localparam logic [31:0] SecPerDay    = 32'd86400;
    localparam logic [31:0] SecPerHour   = 32'd3600;
    localparam logic [31:0] SecPerMin    = 32'd60;
    localparam logic [7:0]  HourNoon     = 8'd12;
    localparam logic [7:0]  HourMax      = 8'd23;
    localparam logic [7:0]  MinuteMax    = 8'd59;
    localparam logic [7:0]  SecondMax    = 8'd60;
    localparam logic [7:0]  MonthMax     = 8'd12;
    localparam logic [3:0]  MonthFeb     = 4'd2;

    // Raw clock-chip register bytes of one word
    typedef struct packed {
        logic [7:0] status;
        logic [7:0] century;
        logic [7:0] year;
        logic [7:0] month;
        logic [7:0] day;
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } raw_fields_t;

    // Decoded and checked parts handed to the seconds stage
    typedef struct packed {
        logic             ok;
        logic [DaysW-1:0] days;
        logic [HourW-1:0] hour;
        logic [MinW-1:0]  minute;
        logic [SecW-1:0]  second;
    } time_parts_t;

    // BCD byte to binary, no digit check: low + 10 * high
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        return (hi << 3) + (hi << 1) + {4'd0, v[3:0]};
    endfunction

    // Days in a month of a common year; codes outside 1..12 give zero
    function automatic logic [4:0] common_month_len(input logic [3:0] mon);
        logic [4:0] d;
        case (mon)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Days of a common year before the first of a month
    function automatic logic [8:0] days_before_month(input logic [3:0] mon);
        logic [8:0] d;
        case (mon)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== src/rtcep_decode.sv =====
// First stage logic: BCD and 12-hour decode, range checks and day count.
// Depends on rtcep_pkg for field types and calendar helpers.
module rtcep_decode
    import rtcep_pkg::*;
(
    input  raw_fields_t raw,
    output time_parts_t parts
);

    logic       binary_mode;
    logic       mode_24h;
    logic       pm;
    logic [7:0] sec_v, min_v, hr_v, day_v, mon_v, yr_v, cen_v;
    logic [7:0] hr_24;
    logic       cen_19, cen_in_range, base_2000, year_ok;
    logic [7:0] year_off_full;
    logic [6:0] year_off;
    logic       leap;
    logic [3:0] mon4;
    logic       mon_ok;
    logic [4:0] max_day;
    logic       day_ok;
    logic       all_ok;
    logic [DaysW-1:0] days;

    assign binary_mode = raw.status[BinaryBit];
    assign mode_24h    = raw.status[Hour24Bit];
    assign pm          = raw.hour[PmBit];

    // Field decode, PM flag stripped from the hour
    always_comb begin
        if (binary_mode) begin
            sec_v = raw.second;
            min_v = raw.minute;
            hr_v  = {1'b0, raw.hour[6:0]};
            day_v = raw.day;
            mon_v = raw.month;
            yr_v  = raw.year;
            cen_v = raw.century;
        end else begin
            sec_v = bcd_to_bin(raw.second);
            min_v = bcd_to_bin(raw.minute);
            hr_v  = bcd_to_bin({1'b0, raw.hour[6:0]});
            day_v = bcd_to_bin(raw.day);
            mon_v = bcd_to_bin(raw.month);
            yr_v  = bcd_to_bin(raw.year);
            cen_v = bcd_to_bin(raw.century);
        end
    end

    // 12-hour to 24-hour mapping
    always_comb begin
        hr_24 = hr_v;
        if (!mode_24h) begin
            if (pm && hr_v < HourNoon) begin
                hr_24 = hr_v + HourNoon;
            end else if (!pm && hr_v == HourNoon) begin
                hr_24 = 8'd0;
            end
        end
    end

    // Year as offset from 1970; centuries 19 and 20, and any outside 19..99 (taken as base 2000), can land in range
    assign cen_19       = (cen_v == CenturyLow);
    assign cen_in_range = (cen_v >= CenturyLow) && (cen_v <= CenturyHigh);
    assign base_2000    = !cen_in_range || (cen_v == Century2000);
    assign year_ok      = (cen_19 && yr_v >= YearMin19 && yr_v <= YearMax19) ||
                          (base_2000 && yr_v <= YearMax20);
    assign year_off_full = cen_19 ? (yr_v - Offset19) : (yr_v + Offset20);
    assign year_off      = year_off_full[6:0];
    // Within 1970..2037 the four-year rule alone decides leap years
    assign leap          = (year_off[1:0] == LeapPhase);

    // Month and day checks
    assign mon4    = mon_v[3:0];
    assign mon_ok  = (mon_v >= 8'd1) && (mon_v <= MonthMax);
    assign max_day = common_month_len(mon4) + {4'd0, (mon4 == MonthFeb) && leap};
    assign day_ok  = (day_v >= 8'd1) && (day_v <= {3'd0, max_day});

    assign all_ok = year_ok && mon_ok && day_ok && (hr_24 <= HourMax) &&
                    (min_v <= MinuteMax) && (sec_v <= SecondMax);

    // Days since 1970-01-01: whole years, leap days before, month, day
    always_comb begin
        days = DaysW'({8'd0, year_off}) * DaysPerYear
             + DaysW'(({1'b0, year_off} + 8'd1) >> 2)
             + DaysW'(days_before_month(mon4))
             + DaysW'((mon4 > MonthFeb) && leap)
             + DaysW'(day_v) - DaysW'(1);
    end

    // Invalid words carry zero parts so the seconds stage yields zero
    always_comb begin
        parts.ok = all_ok;
        if (all_ok) begin
            parts.days   = days;
            parts.hour   = hr_24[HourW-1:0];
            parts.minute = min_v[MinW-1:0];
            parts.second = sec_v[SecW-1:0];
        end else begin
            parts.days   = '0;
            parts.hour   = '0;
            parts.minute = '0;
            parts.second = '0;
        end
    end

endmodule

// ===== src/rtcep_seconds.sv =====
// Second stage logic: weighted sum of days, hours, minutes and seconds.
// Depends on rtcep_pkg for the parts type and time constants.
module rtcep_seconds
    import rtcep_pkg::*;
(
    input  time_parts_t       parts,
    output logic [EpochW-1:0] epoch
);

    logic [31:0] sum;

    // Constant-weight products in parallel, one adder tree
    always_comb begin
        sum = 32'(parts.days) * SecPerDay
            + 32'(parts.hour) * SecPerHour
            + 32'(parts.minute) * SecPerMin
            + 32'(parts.second);
    end

    assign epoch = sum[EpochW-1:0];

endmodule

// ===== src/rtc_fields_to_epoch_seconds.sv =====
// Top level of the RTC fields to epoch seconds converter: handshake and pipeline registers.
// Depends on rtcep_pkg, rtcep_decode and rtcep_seconds.
//
// Channel   Direction  Payload
// s_        in         tdata: raw second, minute, hour, day, month, year, century; tuser: status
// m_        out        tuser: time_valid; tdata: epoch_seconds
//
// One word per cycle sustained while m_tready does not stall; the word passes the input register,
// then the decoded-parts register, and m_tvalid rises when it reaches the result register.
// The split sits after the decode stage so the day count and the seconds sum each
// see one constant multiply level.
// Synchronous active-low reset empties all three stages.
// A stall on m_tready holds the result; upstream stages keep filling until all are full.
module rtc_fields_to_epoch_seconds
    import rtcep_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [7:0] raw_second, [15:8] raw_minute, [23:16] raw_hour, [31:24] raw_day,
    // [39:32] raw_month, [47:40] raw_year, [55:48] raw_century
    input  logic [InDataW-1:0]  s_tdata,
    // [7:0] status_byte
    input  logic [InUserW-1:0]  s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [30:0] epoch_seconds, [31] zero
    output logic [OutDataW-1:0] m_tdata,
    // [0] time_valid
    output logic                m_tuser
);

    raw_fields_t       in_reg;
    logic              in_valid_reg;
    time_parts_t       mid_reg;
    logic              mid_valid_reg;
    logic              out_valid_reg;
    logic              out_ok_reg;
    logic [EpochW-1:0] out_epoch_reg;

    time_parts_t       parts_next;
    logic [EpochW-1:0] epoch_next;
    logic              out_adv, mid_adv, in_adv;

    // Stage advance chain from the output back
    assign out_adv  = !out_valid_reg || m_tready;
    assign mid_adv  = !mid_valid_reg || out_adv;
    assign in_adv   = !in_valid_reg || mid_adv;
    assign s_tready = in_adv;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv && s_tvalid) begin
            in_reg <= raw_fields_t'({s_tuser, s_tdata});
        end
    end

    rtcep_decode u_decode (
        .raw   (in_reg),
        .parts (parts_next)
    );

    // Decoded-parts register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (mid_adv) begin
            mid_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv && in_valid_reg) begin
            mid_reg <= parts_next;
        end
    end

    rtcep_seconds u_seconds (
        .parts (mid_reg),
        .epoch (epoch_next)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= mid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && mid_valid_reg) begin
            out_ok_reg    <= mid_reg.ok;
            out_epoch_reg <= epoch_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_ok_reg;
    assign m_tdata  = {{(OutDataW-EpochW){1'b0}}, out_epoch_reg};

    // An invalid result carries zero seconds
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("invalid result with nonzero seconds");

    // Input is refused only when every stage holds a word
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && mid_valid_reg && out_valid_reg)
        else $error("input stalled with an empty stage");

    // A stalled middle word stays in place
    a_mid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_valid_reg && !out_adv |=> mid_valid_reg && $stable(mid_reg))
        else $error("middle stage lost a stalled word");

    // Results never pass the leap second that closes 2037
    a_epoch_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[EpochW-1:0] <= 31'd2145916800)
        else $error("epoch seconds out of range");

endmodule
